// ----- src/b64sc_pkg.sv -----
// Shared types, constants and character mapping functions for the Base64 stream codec.
package b64sc_pkg;

  localparam int QUEUE_DEPTH = 2;
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 32;

  // Register index is the word address above the byte offset.
  localparam logic [CFG_ADDR_W-3:0] REG_DECODE_MODE = '0;

  localparam logic [7:0] PAD_CHAR       = 8'h3D;
  localparam logic [7:0] INVALID_SEXTET = 8'h80;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_BAD_CHAR = 2'd1,
    STAT_BAD_PAD  = 2'd2
  } status_t;

  // One queued job: up to four result words, slot 0 goes out first.
  typedef struct packed {
    logic [3:0][7:0] data;
    logic [1:0]      last_idx;
    status_t         status;
  } job_t;

  typedef struct packed {
    logic decode_mode;
    logic clear;
  } cfg_ctl_t;

  function automatic logic [7:0] enc_char(input logic [5:0] sextet);
    logic [7:0] s8;
    logic [7:0] ch;
    s8 = {2'b00, sextet};
    if (sextet < 6'd26) begin
      ch = 8'h41 + s8;
    end else if (sextet < 6'd52) begin
      ch = 8'h61 + s8 - 8'd26;
    end else if (sextet < 6'd62) begin
      ch = 8'h30 + s8 - 8'd52;
    end else if (sextet == 6'd62) begin
      ch = 8'h2B;
    end else begin
      ch = 8'h2F;
    end
    return ch;
  endfunction

  // Sextet of an alphabet character, or INVALID_SEXTET otherwise.
  function automatic logic [7:0] dec_value(input logic [7:0] c);
    logic [7:0] v;
    if (c >= 8'h41 && c <= 8'h5A) begin
      v = c - 8'h41;
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      v = c - 8'h61 + 8'd26;
    end else if (c >= 8'h30 && c <= 8'h39) begin
      v = c - 8'h30 + 8'd52;
    end else if (c == 8'h2B) begin
      v = 8'd62;
    end else if (c == 8'h2F) begin
      v = 8'd63;
    end else begin
      v = INVALID_SEXTET;
    end
    return v;
  endfunction

endpackage

// ----- src/base64_stream_codec.sv -----
// Result path: the input word that closes a job writes the job into the job queue; the job
// is then loaded into the back-end word register once the back end is free, and only then
// is its first result word on the result ports. Throughput: one input word per cycle while
// the job queue has room; one result word per cycle from the back end while pop is held,
// so encoding is bound by the back end (four characters per three bytes) and decoding by the input side.
// Reset: synchronous, active low; clears the mode to encode, the group state and the
// job queue.
module base64_stream_codec #(
  parameter int QUEUE_DEPTH = b64sc_pkg::QUEUE_DEPTH
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [b64sc_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [b64sc_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [b64sc_pkg::CFG_DATA_W-1:0] prdata,
  output logic                             pready,
  input  logic [7:0]                       in_byte,
  input  logic                             in_last,
  input  logic                             push,
  output logic                             full,
  output logic [7:0]                       out_byte,
  output logic                             out_last,
  output logic [1:0]                       out_status,
  output logic                             empty,
  input  logic                             pop
);

  logic               decode_mode_r;
  logic               reg_hit;
  logic               cfg_wr;
  b64sc_pkg::cfg_ctl_t cfg;
  logic               accept;
  logic               job_valid;
  b64sc_pkg::job_t    job_in, job_out;
  logic               q_full, q_empty, q_pop;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[b64sc_pkg::CFG_ADDR_W-1:2] == b64sc_pkg::REG_DECODE_MODE);
  assign cfg_wr  = psel && penable && pwrite && pready && reg_hit;
  assign prdata  = reg_hit ? {{(b64sc_pkg::CFG_DATA_W-1){1'b0}}, decode_mode_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decode_mode_r <= 1'b0;
    end else if (cfg_wr) begin
      decode_mode_r <= pwdata[0];
    end
  end

  assign cfg.decode_mode = decode_mode_r;
  assign cfg.clear       = cfg_wr;

  assign full   = q_full;
  assign accept = push && !q_full;

  b64sc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .accept    (accept),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .job_valid (job_valid),
    .job       (job_in)
  );

  b64sc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (accept && job_valid),
    .job_in  (job_in),
    .pop     (q_pop),
    .job_out (job_out),
    .full    (q_full),
    .empty   (q_empty)
  );

  b64sc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_job      (job_out),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .pop        (pop),
    .empty      (empty),
    .out_byte   (out_byte),
    .out_last   (out_last),
    .out_status (out_status)
  );

`ifndef ASSERT_OFF
  a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_status != b64sc_pkg::STAT_OK) |-> out_last)
    else $error("error word not marked last");

  a_enc_no_err: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !decode_mode_r) |-> (out_status == b64sc_pkg::STAT_OK))
    else $error("error status while encoding");

  a_job_whole: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !empty && !out_last) |=> !empty)
    else $error("job ended before its last word");
`endif

endmodule

// ----- src/b64sc_front.sv -----
// Front end: takes input words, keeps the group state and builds result jobs.
module b64sc_front (
  input  logic                clk,
  input  logic                rst_n,
  input  b64sc_pkg::cfg_ctl_t cfg,
  input  logic                accept,
  input  logic [7:0]          in_byte,
  input  logic                in_last,
  output logic                job_valid,
  output b64sc_pkg::job_t     job
);

  logic [23:0] group_bits_r, group_bits_nxt;
  logic [1:0]  group_count_r, group_count_nxt;
  logic [1:0]  pad_count_r, pad_count_nxt;

  // encode path
  logic [1:0]  enc_cnt;
  logic [23:0] enc_shift;
  logic [23:0] enc_word;
  logic        enc_emit;
  logic [1:0]  enc_npad;
  logic [3:0][7:0] enc_chars;

  // decode path
  logic        is_pad;
  logic [7:0]  dv;
  logic [5:0]  sextet;
  logic [1:0]  pad_new;
  logic        dec_err;
  b64sc_pkg::status_t dec_code;
  logic [23:0] dec_shift;

  always_comb begin
    enc_cnt   = group_count_r + 2'd1;
    enc_shift = {group_bits_r[15:0], in_byte};
    unique case (enc_cnt)
      2'd3: begin
        enc_word = enc_shift;
        enc_emit = 1'b1;
        enc_npad = 2'd0;
      end
      2'd1: begin
        enc_word = {in_byte, 16'h0000};
        enc_emit = in_last;
        enc_npad = 2'd2;
      end
      2'd2: begin
        enc_word = {group_bits_r[7:0], in_byte, 8'h00};
        enc_emit = in_last;
        enc_npad = 2'd1;
      end
      2'd0: begin
        enc_word = enc_shift;
        enc_emit = 1'b0;
        enc_npad = 2'd0;
      end
    endcase
    enc_chars[0] = b64sc_pkg::enc_char(enc_word[23:18]);
    enc_chars[1] = b64sc_pkg::enc_char(enc_word[17:12]);
    enc_chars[2] = (enc_npad == 2'd2) ? b64sc_pkg::PAD_CHAR
                                      : b64sc_pkg::enc_char(enc_word[11:6]);
    enc_chars[3] = (enc_npad != 2'd0) ? b64sc_pkg::PAD_CHAR
                                      : b64sc_pkg::enc_char(enc_word[5:0]);
  end

  always_comb begin
    is_pad   = (in_byte == b64sc_pkg::PAD_CHAR);
    dv       = b64sc_pkg::dec_value(in_byte);
    sextet   = 6'd0;
    pad_new  = pad_count_r;
    dec_err  = 1'b0;
    dec_code = b64sc_pkg::STAT_OK;
    if (is_pad) begin
      // a pad in the first or second place is misplaced
      if (group_count_r < 2'd2) begin
        dec_err  = 1'b1;
        dec_code = b64sc_pkg::STAT_BAD_PAD;
      end else begin
        pad_new = pad_count_r + 2'd1;
      end
    end else if (dv[7]) begin
      dec_err  = 1'b1;
      dec_code = b64sc_pkg::STAT_BAD_CHAR;
    end else if (pad_count_r != 2'd0) begin
      dec_err  = 1'b1;
      dec_code = b64sc_pkg::STAT_BAD_PAD;
    end else begin
      sextet = dv[5:0];
    end
    dec_shift = {group_bits_r[17:0], sextet};
  end

  always_comb begin
    job_valid       = 1'b0;
    job.data        = '0;
    job.last_idx    = 2'd0;
    job.status      = b64sc_pkg::STAT_OK;
    group_bits_nxt  = group_bits_r;
    group_count_nxt = group_count_r;
    pad_count_nxt   = pad_count_r;
    if (!cfg.decode_mode) begin
      job.data     = enc_chars;
      job.last_idx = 2'd3;
      job_valid    = enc_emit;
      if (enc_emit) begin
        group_bits_nxt  = '0;
        group_count_nxt = 2'd0;
      end else begin
        group_bits_nxt  = enc_shift;
        group_count_nxt = enc_cnt;
      end
      pad_count_nxt = 2'd0;
    end else begin
      priority if (dec_err) begin
        job_valid       = 1'b1;
        job.status      = dec_code;
        group_bits_nxt  = '0;
        group_count_nxt = 2'd0;
        pad_count_nxt   = 2'd0;
      end else if (group_count_r == 2'd3) begin
        job_valid       = 1'b1;
        job.data[0]     = dec_shift[23:16];
        job.data[1]     = dec_shift[15:8];
        job.data[2]     = dec_shift[7:0];
        job.last_idx    = 2'd2 - pad_new;
        group_bits_nxt  = '0;
        group_count_nxt = 2'd0;
        pad_count_nxt   = 2'd0;
      end else if (in_last) begin
        // truncated group at end of message
        job_valid       = 1'b1;
        job.status      = b64sc_pkg::STAT_BAD_PAD;
        group_bits_nxt  = '0;
        group_count_nxt = 2'd0;
        pad_count_nxt   = 2'd0;
      end else begin
        group_bits_nxt  = dec_shift;
        group_count_nxt = group_count_r + 2'd1;
        pad_count_nxt   = pad_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg.clear) begin
      group_bits_r  <= '0;
      group_count_r <= 2'd0;
      pad_count_r   <= 2'd0;
    end else if (accept) begin
      group_bits_r  <= group_bits_nxt;
      group_count_r <= group_count_nxt;
      pad_count_r   <= pad_count_nxt;
    end
  end

endmodule

// ----- src/b64sc_queue.sv -----
// Short job queue between the front and back ends.
module b64sc_queue #(
  parameter int DEPTH = b64sc_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  b64sc_pkg::job_t job_in,
  input  logic            pop,
  output b64sc_pkg::job_t job_out,
  output logic            full,
  output logic            empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  b64sc_pkg::job_t mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign job_out = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= job_in;
    end
  end

endmodule

// ----- src/b64sc_back.sv -----
// Back end: walks each job out as result words, one per cycle while pop is held.
module b64sc_back (
  input  logic            clk,
  input  logic            rst_n,
  input  b64sc_pkg::job_t q_job,
  input  logic            q_empty,
  output logic            q_pop,
  input  logic            pop,
  output logic            empty,
  output logic [7:0]      out_byte,
  output logic            out_last,
  output logic [1:0]      out_status
);

  b64sc_pkg::job_t cur_r;
  logic [1:0]      idx_r;
  logic            busy_r;
  logic            take, done, load;

  assign take  = pop && busy_r;
  assign done  = take && (idx_r == cur_r.last_idx);
  // refill when idle, or as the last word of the current job leaves
  assign load  = !q_empty && (!busy_r || done);
  assign q_pop = load;

  assign empty      = !busy_r;
  assign out_byte   = cur_r.data[idx_r];
  assign out_last   = (idx_r == cur_r.last_idx);
  assign out_status = cur_r.status;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= 2'd0;
    end else if (load) begin
      busy_r <= 1'b1;
      idx_r  <= 2'd0;
    end else if (done) begin
      busy_r <= 1'b0;
      idx_r  <= 2'd0;
    end else if (take) begin
      idx_r <= idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur_r <= q_job;
    end
  end

endmodule

// ----- verif/tb_base64_stream_codec.sv -----
// Self-checking testbench for the Base64 stream codec: directed table, then random messages.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT   = 2000;
  localparam int HOLD_AT       = 40;
  localparam int HOLD_CYCLES   = 80;
  localparam int N_PHASES      = 6;
  localparam int PHASE_ITEMS   = 38;
  localparam int SETTLE_CYCLES = 8;
  localparam int N_ROWS        = 25;

  localparam logic [b64sc_pkg::CFG_ADDR_W-3:0] REG_SPARE = 1'b1;
  localparam logic [64*8-1:0] ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  typedef struct packed {
    logic [7:0]         data;
    logic               fin;
    b64sc_pkg::status_t st;
  } codec_word_t;

  // n_typed == 0: take the words from the predictor
  typedef struct packed {
    logic               mode;
    logic [7:0]         chr;
    logic               fin;
    logic [2:0]         n_typed;
    logic [31:0]        typed;
    b64sc_pkg::status_t st;
  } stim_row_t;

  typedef enum {FLAW_CHAR, FLAW_PAD, FLAW_CUT} flaw_t;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             psel = 1'b0;
  logic                             penable = 1'b0;
  logic                             pwrite = 1'b0;
  logic [b64sc_pkg::CFG_ADDR_W-1:0] paddr = '0;
  logic [b64sc_pkg::CFG_DATA_W-1:0] pwdata = '0;
  logic [b64sc_pkg::CFG_DATA_W-1:0] prdata;
  logic                             pready;
  logic [7:0]                       in_byte = '0;
  logic                             in_last = 1'b0;
  logic                             push = 1'b0;
  logic                             full;
  logic [7:0]                       out_byte;
  logic                             out_last;
  logic [1:0]                       out_status;
  logic                             empty;
  logic                             pop = 1'b0;

  // predictor state
  logic        dec_mode = 1'b0;
  logic [23:0] grp_bits = '0;
  logic [1:0]  grp_cnt = '0;
  logic [1:0]  pad_cnt = '0;

  codec_word_t expected_words[$];
  codec_word_t step_words[$];
  logic [7:0]  msg_chars[$];
  int          fail_count = 0;
  int          items_sent = 0;
  int          words_seen = 0;
  int          quiet_cycles = 0;
  int          gap_max = 6;

  stim_row_t stim_rows [0:N_ROWS-1] = '{
    // encode: one-byte tail, two-byte tail, last on a full group, all-ones group
    {1'b0, 8'h00, 1'b1, 3'd4, "AA==", b64sc_pkg::STAT_OK},
    {1'b0, 8'hFF, 1'b0, 3'd0, 32'h0,  b64sc_pkg::STAT_OK},
    {1'b0, 8'hFF, 1'b1, 3'd4, "//8=", b64sc_pkg::STAT_OK},
    {1'b0, 8'h00, 1'b0, 3'd0, 32'h0,  b64sc_pkg::STAT_OK},
    {1'b0, 8'h00, 1'b0, 3'd0, 32'h0,  b64sc_pkg::STAT_OK},
    {1'b0, 8'h00, 1'b1, 3'd4, "AAAA", b64sc_pkg::STAT_OK},
    {1'b0, 8'hFF, 1'b0, 3'd0, 32'h0,  b64sc_pkg::STAT_OK},
    {1'b0, 8'hFF, 1'b0, 3'd0, 32'h0,  b64sc_pkg::STAT_OK},
    {1'b0, 8'hFF, 1'b0, 3'd4, "////", b64sc_pkg::STAT_OK},
    // decode: full group marked last
    {1'b1, "T",   1'b0, 3'd0, 32'h0,  b64sc_pkg::STAT_OK},
    {1'b1, "W",   1'b0, 3'd0, 32'h0,  b64sc_pkg::STAT_OK},
    {1'b1, "F",   1'b0, 3'd0, 32'h0,  b64sc_pkg::STAT_OK},
    {1'b1, "u",   1'b1, 3'd0, 32'h0,  b64sc_pkg::STAT_OK},
    // pad in second place
    {1'b1, "A",   1'b0, 3'd0, 32'h0,  b64sc_pkg::STAT_OK},
    {1'b1, "=",   1'b0, 3'd1, 32'h0,  b64sc_pkg::STAT_BAD_PAD},
    // two pads give one byte
    {1'b1, "A",   1'b0, 3'd0, 32'h0,  b64sc_pkg::STAT_OK},
    {1'b1, "A",   1'b0, 3'd0, 32'h0,  b64sc_pkg::STAT_OK},
    {1'b1, "=",   1'b0, 3'd0, 32'h0,  b64sc_pkg::STAT_OK},
    {1'b1, "=",   1'b0, 3'd1, 32'h0,  b64sc_pkg::STAT_OK},
    // byte above the ASCII range
    {1'b1, 8'hFF, 1'b0, 3'd1, 32'h0,  b64sc_pkg::STAT_BAD_CHAR},
    // character after a pad
    {1'b1, "Q",   1'b0, 3'd0, 32'h0,  b64sc_pkg::STAT_OK},
    {1'b1, "Q",   1'b0, 3'd0, 32'h0,  b64sc_pkg::STAT_OK},
    {1'b1, "=",   1'b0, 3'd0, 32'h0,  b64sc_pkg::STAT_OK},
    {1'b1, "A",   1'b0, 3'd1, 32'h0,  b64sc_pkg::STAT_BAD_PAD},
    // truncated group
    {1'b1, "A",   1'b1, 3'd1, 32'h0,  b64sc_pkg::STAT_BAD_PAD}
  };

  base64_stream_codec i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .push      (push),
    .full      (full),
    .out_byte  (out_byte),
    .out_last  (out_last),
    .out_status(out_status),
    .empty     (empty),
    .pop       (pop)
  );

  always #5 clk = ~clk;

  function automatic logic [7:0] sextet_char(input logic [5:0] sx);
    return ALPHABET[(63 - int'(sx)) * 8 +: 8];
  endfunction

  function automatic int char_sextet(input logic [7:0] c);
    for (int j = 0; j < 64; j++) begin
      if (ALPHABET[(63 - j) * 8 +: 8] == c) return j;
    end
    return -1;
  endfunction

  function automatic void clear_group();
    grp_bits = '0;
    grp_cnt  = '0;
    pad_cnt  = '0;
  endfunction

  function automatic void put_word(input logic [7:0] d, input logic fin);
    step_words.push_back({d, fin, b64sc_pkg::STAT_OK});
  endfunction

  function automatic void raise_error(input b64sc_pkg::status_t st);
    clear_group();
    step_words.push_back({8'h00, 1'b1, st});
  endfunction

  // Advance the group state by one word and collect the words it releases.
  function automatic void codec_predict(input logic [7:0] chr, input logic fin);
    int sx;
    step_words.delete();
    if (!dec_mode) begin
      grp_bits = {grp_bits[15:0], chr};
      grp_cnt  = grp_cnt + 2'd1;
      if (grp_cnt == 2'd3) begin
        put_word(sextet_char(grp_bits[23:18]), 1'b0);
        put_word(sextet_char(grp_bits[17:12]), 1'b0);
        put_word(sextet_char(grp_bits[11:6]), 1'b0);
        put_word(sextet_char(grp_bits[5:0]), 1'b1);
        clear_group();
      end else if (fin && grp_cnt == 2'd1) begin
        put_word(sextet_char(grp_bits[7:2]), 1'b0);
        put_word(sextet_char({grp_bits[1:0], 4'h0}), 1'b0);
        put_word(b64sc_pkg::PAD_CHAR, 1'b0);
        put_word(b64sc_pkg::PAD_CHAR, 1'b1);
        clear_group();
      end else if (fin && grp_cnt == 2'd2) begin
        put_word(sextet_char(grp_bits[15:10]), 1'b0);
        put_word(sextet_char(grp_bits[9:4]), 1'b0);
        put_word(sextet_char({grp_bits[3:0], 2'b00}), 1'b0);
        put_word(b64sc_pkg::PAD_CHAR, 1'b1);
        clear_group();
      end
      return;
    end
    if (chr == b64sc_pkg::PAD_CHAR) begin
      if (grp_cnt < 2'd2) begin
        raise_error(b64sc_pkg::STAT_BAD_PAD);
        return;
      end
      sx = 0;
      pad_cnt = pad_cnt + 2'd1;
    end else begin
      sx = char_sextet(chr);
      if (sx < 0) begin
        raise_error(b64sc_pkg::STAT_BAD_CHAR);
        return;
      end
      if (pad_cnt != 2'd0) begin
        raise_error(b64sc_pkg::STAT_BAD_PAD);
        return;
      end
    end
    grp_bits = {grp_bits[17:0], sx[5:0]};
    if (grp_cnt == 2'd3) begin
      put_word(grp_bits[23:16], pad_cnt == 2'd2);
      if (pad_cnt < 2'd2) put_word(grp_bits[15:8], pad_cnt == 2'd1);
      if (pad_cnt == 2'd0) put_word(grp_bits[7:0], 1'b1);
      clear_group();
    end else begin
      grp_cnt = grp_cnt + 2'd1;
      if (fin) raise_error(b64sc_pkg::STAT_BAD_PAD);
    end
  endfunction

  task automatic send_word(input logic [7:0] chr, input logic fin, input logic [2:0] n_typed,
                           input logic [31:0] typed, input b64sc_pkg::status_t st);
    int gap;
    gap = $urandom_range(0, gap_max);
    repeat (gap) begin
      @(negedge clk);
      push <= 1'b0;
    end
    @(negedge clk);
    push    <= 1'b1;
    in_byte <= chr;
    in_last <= fin;
    @(posedge clk);
    while (full) @(posedge clk);
    items_sent++;
    codec_predict(chr, fin);
    if (n_typed == 3'd0) begin
      foreach (step_words[k]) expected_words.push_back(step_words[k]);
    end else begin
      for (int k = 0; k < n_typed; k++) begin
        expected_words.push_back({typed[31 - 8 * k -: 8], k == n_typed - 1, st});
      end
    end
  endtask

  task automatic cfg_write(input logic [b64sc_pkg::CFG_ADDR_W-3:0] idx,
                           input logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (idx == b64sc_pkg::REG_DECODE_MODE) begin
      dec_mode = value[0];
      clear_group();
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_mode_reg();
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {b64sc_pkg::REG_DECODE_MODE, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== {31'b0, dec_mode}) begin
      $display("%0t: mode register mismatch: expected %08h, got %08h",
               $time, {31'b0, dec_mode}, prdata);
      fail_count++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Drop push, wait for every expected word, then let a partial group settle.
  task automatic drain_codec();
    @(negedge clk);
    push <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : result_sink
    int stall;
    codec_word_t got;
    codec_word_t want;
    wait (rst_n);
    forever begin
      // hold off once for a long stretch so the codec fills and stalls its input
      stall = (words_seen == HOLD_AT) ? HOLD_CYCLES : $urandom_range(0, gap_max);
      repeat (stall) begin
        @(negedge clk);
        pop <= 1'b0;
      end
      @(negedge clk);
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
      got = {out_byte, out_last, b64sc_pkg::status_t'(out_status)};
      words_seen++;
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected word: expected none, got byte %02h last %0b status %0d",
                 $time, got.data, got.fin, got.st);
        fail_count++;
      end else begin
        want = expected_words.pop_front();
        if (got.data !== want.data || got.fin !== want.fin || got.st !== want.st) begin
          $display("%0t: mismatch: expected %02h/%0b/%0d, got %02h/%0b/%0d",
                   $time, want.data, want.fin, want.st, got.data, got.fin, got.st);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin : stimulus
    int    len;
    int    npad;
    int    pos;
    int    target;
    int    n;
    flaw_t flaw;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    check_mode_reg();

    for (int i = 0; i < N_ROWS; i++) begin
      if (stim_rows[i].mode != dec_mode) begin
        drain_codec();
        cfg_write(b64sc_pkg::REG_DECODE_MODE, {31'b0, stim_rows[i].mode});
        check_mode_reg();
      end
      send_word(stim_rows[i].chr, stim_rows[i].fin, stim_rows[i].n_typed,
                stim_rows[i].typed, stim_rows[i].st);
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      drain_codec();
      if ($urandom_range(0, 1)) cfg_write(REG_SPARE, $urandom());
      cfg_write(b64sc_pkg::REG_DECODE_MODE, ($urandom() & 32'hFFFF_FFFE) | (ph & 1));
      check_mode_reg();
      gap_max = (ph == 2) ? 0 : 6;
      target  = items_sent + PHASE_ITEMS;
      while (items_sent < target) begin
        msg_chars.delete();
        if (!dec_mode) begin
          len = $urandom_range(1, 9);
          repeat (len) msg_chars.push_back(8'($urandom_range(0, 255)));
        end else begin
          repeat (4 * $urandom_range(1, 3)) begin
            msg_chars.push_back(sextet_char(6'($urandom_range(0, 63))));
          end
          npad = $urandom_range(0, 2);
          for (int k = 0; k < npad; k++) begin
            msg_chars[msg_chars.size() - 1 - k] = b64sc_pkg::PAD_CHAR;
          end
          // break about one message in four
          if ($urandom_range(0, 3) == 0) begin
            flaw = flaw_t'($urandom_range(0, 2));
            pos  = $urandom_range(0, msg_chars.size() - 1);
            case (flaw)
              FLAW_CHAR: msg_chars[pos] = 8'($urandom_range(0, 255));
              FLAW_PAD:  msg_chars[pos] = b64sc_pkg::PAD_CHAR;
              default: begin
                repeat ($urandom_range(1, 3)) void'(msg_chars.pop_back());
              end
            endcase
          end
        end
        for (int k = 0; k < msg_chars.size(); k++) begin
          send_word(msg_chars[k], k == msg_chars.size() - 1, 3'd0, 32'h0,
                    b64sc_pkg::STAT_OK);
        end
      end
    end

    @(negedge clk);
    push <= 1'b0;
    n = 0;
    while (expected_words.size() != 0 && n < QUIET_LIMIT) begin
      @(posedge clk);
      n++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_words.size() != 0) begin
      $display("%0t: %0d expected words never arrived", $time, expected_words.size());
    end
    if (fail_count == 0 && expected_words.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
